// ===== sv/tile_channel_coincidence_counter_assert.svh =====
// Assertion macros shared by the coincidence counter modules.
`ifndef TILE_CHANNEL_COINCIDENCE_COUNTER_ASSERT_SVH
`define TILE_CHANNEL_COINCIDENCE_COUNTER_ASSERT_SVH

// same-cycle implication, clocked on clk, disabled in reset
`define TCCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, disabled in reset
`define TCCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tccc_pkg.sv =====
// Shared constants and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none
package tccc_pkg;

  localparam int TILE_SIDE_DEF    = 16;
  localparam int VALUE_LEVELS_DEF = 256;
  localparam int FIELD_W          = 9;
  localparam int FIELD_MAX        = 511;
  localparam int PIX_W            = 8;

  typedef struct packed {
    logic sweep_en;     // clear presence entry at sweep address, advance address
    logic scan_read;    // the sweep read is counted
    logic acc_clr;      // clear coincidence counters
    logic pixel_inc;    // a pixel word is accepted this cycle
    logic load_result;  // move counts to the output register
  } cmd_t;

  typedef struct packed {
    logic addr_last;    // sweep address is at the final level
    logic out_free;     // output register can take a result
  } status_t;

endpackage
`default_nettype wire

// ===== sv/tccc_ctrl.sv =====
// Controller: reset clear sweep, tile accumulation, scan and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
`include "tile_channel_coincidence_counter_assert.svh"
module tccc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              last_in_tile,
  input  wire tccc_pkg::status_t status,
  output logic                   in_ready,
  output tccc_pkg::cmd_t         cmd
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_ACCUM = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [2:0] state, state_next;
  logic       accept;

  assign in_ready = (state == ST_ACCUM);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.sweep_en = 1'b1;
        if (status.addr_last) state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd.pixel_inc = accept;
        if (accept && last_in_tile) begin
          cmd.acc_clr = 1'b1;
          state_next  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.sweep_en  = 1'b1;
        cmd.scan_read = 1'b1;
        if (status.addr_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (status.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = ST_ACCUM;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  `TCCC_ASSERT_NEXT(a_last_starts_scan, accept && last_in_tile, state == ST_SCAN, "last word did not start scan")
  `TCCC_ASSERT_NEXT(a_scan_end_drains, state == ST_SCAN && status.addr_last, state == ST_DRAIN, "scan did not end at last level")

endmodule
`default_nettype wire

// ===== sv/tccc_datapath.sv =====
// Datapath: per-channel presence memories, sweep counter, coincidence counters, output register.
`timescale 1ns / 1ps
`default_nettype none
`include "tile_channel_coincidence_counter_assert.svh"
module tccc_datapath #(
  parameter int TILE_SIDE    = tccc_pkg::TILE_SIDE_DEF,
  parameter int VALUE_LEVELS = tccc_pkg::VALUE_LEVELS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [tccc_pkg::PIX_W-1:0]      red,
  input  wire logic [tccc_pkg::PIX_W-1:0]      green,
  input  wire logic [tccc_pkg::PIX_W-1:0]      blue,
  input  wire tccc_pkg::cmd_t                  cmd,
  output tccc_pkg::status_t                    status,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [tccc_pkg::FIELD_W-1:0]         triple_count,
  output logic [tccc_pkg::FIELD_W-1:0]         pair_count,
  output logic [tccc_pkg::FIELD_W-1:0]         single_count,
  output logic [tccc_pkg::FIELD_W-1:0]         active_count,
  output logic [tccc_pkg::FIELD_W-1:0]         pixel_count
);

  localparam int FW    = tccc_pkg::FIELD_W;
  localparam int AW    = $clog2(VALUE_LEVELS);
  localparam int AVW   = (AW + 1 > tccc_pkg::PIX_W + 1) ? AW + 1 : tccc_pkg::PIX_W + 1;
  localparam int CLG   = $clog2(VALUE_LEVELS + 1);
  localparam int CW    = (CLG > FW) ? CLG : FW;
  localparam int AREA  = TILE_SIDE * TILE_SIDE;
  localparam int PIX_LIMIT = (AREA > tccc_pkg::FIELD_MAX) ? tccc_pkg::FIELD_MAX : AREA;
  localparam logic [AW-1:0]  ADDR_LAST = AW'(VALUE_LEVELS - 1);
  localparam logic [AVW-1:0] LEVELS_EXT = AVW'(VALUE_LEVELS);
  localparam logic [CW-1:0]  CNT_MAX = CW'(tccc_pkg::FIELD_MAX);
  localparam logic [FW-1:0]  SAT_MAX = FW'(tccc_pkg::FIELD_MAX);

  logic mem_r [VALUE_LEVELS];
  logic mem_g [VALUE_LEVELS];
  logic mem_b [VALUE_LEVELS];

  logic [AW-1:0]  sweep_addr;
  logic [AVW-1:0] r_ext, g_ext, b_ext;
  logic           r_hit, g_hit, b_hit;
  logic [AW-1:0]  r_addr, g_addr, b_addr;
  logic           rd_r, rd_g, rd_b;
  logic           rd_count;
  logic [1:0]     n_ch;
  logic [CW-1:0]  tri_cnt, pair_cnt, sing_cnt, act_cnt;
  logic [FW-1:0]  pix_cnt;

  assign r_ext  = AVW'(red);
  assign g_ext  = AVW'(green);
  assign b_ext  = AVW'(blue);
  assign r_hit  = r_ext < LEVELS_EXT;
  assign g_hit  = g_ext < LEVELS_EXT;
  assign b_hit  = b_ext < LEVELS_EXT;
  assign r_addr = r_ext[AW-1:0];
  assign g_addr = g_ext[AW-1:0];
  assign b_addr = b_ext[AW-1:0];

  assign status.addr_last = (sweep_addr == ADDR_LAST);
  assign status.out_free  = !out_valid || out_ready;

  // presence memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (cmd.sweep_en) begin
      mem_r[sweep_addr] <= 1'b0;
    end else if (cmd.pixel_inc && r_hit) begin
      mem_r[r_addr] <= 1'b1;
    end
    rd_r <= mem_r[sweep_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_en) begin
      mem_g[sweep_addr] <= 1'b0;
    end else if (cmd.pixel_inc && g_hit) begin
      mem_g[g_addr] <= 1'b1;
    end
    rd_g <= mem_g[sweep_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_en) begin
      mem_b[sweep_addr] <= 1'b0;
    end else if (cmd.pixel_inc && b_hit) begin
      mem_b[b_addr] <= 1'b1;
    end
    rd_b <= mem_b[sweep_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      rd_count   <= 1'b0;
    end else begin
      rd_count <= cmd.scan_read;
      if (cmd.sweep_en) begin
        sweep_addr <= status.addr_last ? '0 : sweep_addr + AW'(1);
      end
    end
  end

  assign n_ch = 2'(rd_r) + 2'(rd_g) + 2'(rd_b);

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      tri_cnt  <= '0;
      pair_cnt <= '0;
      sing_cnt <= '0;
      act_cnt  <= '0;
    end else if (rd_count) begin
      if (n_ch == 2'd3) tri_cnt  <= tri_cnt + CW'(1);
      if (n_ch == 2'd2) pair_cnt <= pair_cnt + CW'(1);
      if (n_ch == 2'd1) sing_cnt <= sing_cnt + CW'(1);
      if (n_ch != 2'd0) act_cnt  <= act_cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_cnt <= '0;
    end else if (cmd.load_result) begin
      pix_cnt <= '0;
    end else if (cmd.pixel_inc && (pix_cnt < FW'(PIX_LIMIT))) begin
      pix_cnt <= pix_cnt + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      triple_count <= (tri_cnt  > CNT_MAX) ? SAT_MAX : tri_cnt[FW-1:0];
      pair_count   <= (pair_cnt > CNT_MAX) ? SAT_MAX : pair_cnt[FW-1:0];
      single_count <= (sing_cnt > CNT_MAX) ? SAT_MAX : sing_cnt[FW-1:0];
      active_count <= (act_cnt  > CNT_MAX) ? SAT_MAX : act_cnt[FW-1:0];
      pixel_count  <= pix_cnt;
    end
  end

  `TCCC_ASSERT_NOW(a_read_with_sweep, cmd.scan_read, cmd.sweep_en, "scan read without sweep")
  `TCCC_ASSERT_NOW(a_load_slot_free, cmd.load_result, !out_valid || out_ready, "result overwrites pending word")
  `TCCC_ASSERT_NOW(a_load_has_pixels, cmd.load_result, pix_cnt != '0, "result with empty tile")
  `TCCC_ASSERT_NOW(a_active_sum, cmd.load_result, (CW + 2)'(act_cnt) == (CW + 2)'(tri_cnt) + (CW + 2)'(pair_cnt) + (CW + 2)'(sing_cnt), "active count mismatch")

endmodule
`default_nettype wire

// ===== sv/tile_channel_coincidence_counter.sv =====
// Top level: tile channel coincidence counter.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------------
//  in      | in_valid / in_ready  | red, green, blue, last_in_tile
//  out     | out_valid / out_ready| triple_count, pair_count, single_count,
//          |                      | active_count, pixel_count
//
// Pixel words are taken one per cycle within a tile.
// After the last word of a tile, the presence memories are scanned and cleared at
// one level per cycle; no word is taken until the scan, a drain step and the result hand-off are done.
// A result still waiting in the output register holds the next result, and the input with it.
// After reset a clear sweep over all VALUE_LEVELS levels runs before the first word is taken.
`timescale 1ns / 1ps
`default_nettype none
module tile_channel_coincidence_counter #(
  parameter int TILE_SIDE    = tccc_pkg::TILE_SIDE_DEF,
  parameter int VALUE_LEVELS = tccc_pkg::VALUE_LEVELS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [tccc_pkg::PIX_W-1:0]  red,
  input  wire logic [tccc_pkg::PIX_W-1:0]  green,
  input  wire logic [tccc_pkg::PIX_W-1:0]  blue,
  input  wire logic                        last_in_tile,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [tccc_pkg::FIELD_W-1:0]     triple_count,
  output logic [tccc_pkg::FIELD_W-1:0]     pair_count,
  output logic [tccc_pkg::FIELD_W-1:0]     single_count,
  output logic [tccc_pkg::FIELD_W-1:0]     active_count,
  output logic [tccc_pkg::FIELD_W-1:0]     pixel_count
);

  tccc_pkg::cmd_t    cmd;
  tccc_pkg::status_t status;

  tccc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .last_in_tile (last_in_tile),
    .status       (status),
    .in_ready     (in_ready),
    .cmd          (cmd)
  );

  tccc_datapath #(
    .TILE_SIDE    (TILE_SIDE),
    .VALUE_LEVELS (VALUE_LEVELS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .triple_count (triple_count),
    .pair_count   (pair_count),
    .single_count (single_count),
    .active_count (active_count),
    .pixel_count  (pixel_count)
  );

endmodule
`default_nettype wire
